/* rtl/core/mhbag_pkg.sv */
// ----------------------------------------------------------------------------
// mhbag_pkg
// Shared widths, register indexes and reset values for the block address
// generator and its port checker.
// ----------------------------------------------------------------------------
`default_nettype none

package mhbag_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_BPT = 1'd0;  // blocks_per_thread
  localparam logic [CFG_IDX_W-1:0] REG_TC  = 1'd1;  // thread_count

  localparam int unsigned BPT_W = 21;
  localparam int unsigned TC_W  = 8;
  localparam logic [BPT_W-1:0] BPT_RESET = 21'd1024;
  localparam logic [TC_W-1:0]  TC_RESET  = 8'd1;

  // field widths
  localparam int unsigned DONE_W = 20;
  localparam int unsigned THR_W  = 8;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned GIDX_W = 28;

  // result beat: source, previous, destination, padded to bytes
  localparam int unsigned OUT_W = ((3 * GIDX_W + 7) / 8) * 8;

  // remainder unit: one dividend bit per step, DIV_STEP steps per stage
  localparam int unsigned DIV_STEP   = 4;
  localparam int unsigned DIV_STAGES = WORD_W / DIV_STEP;

endpackage

`default_nettype wire

/* rtl/core/memory_hard_block_address_gen.sv */
// ----------------------------------------------------------------------------
// memory_hard_block_address_gen
// Source / previous / destination block index generator for a memory-hard
// hash, independent (sliding bit reversal) and dependent (cubic distance).
// ----------------------------------------------------------------------------
// channel | dir | handshake               | payload
// in_     | in  | in_tvalid / in_tready   | tuser: req_type; tdata: request
// out_    | out | out_tvalid / out_tready | tdata: source, previous, dest
// cfg_    | in  | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One beat per cycle while out_ is not stalled. The depth comes from the modulo
// by thread_count: a restoring remainder unit retiring 4 dividend bits per
// stage over 8 stages, then the multiply by blocks_per_thread and the add.
// A stall on out_ freezes the whole pipe; in_tready drops with it.
// Synchronous active-low reset clears the valid bits and resets the configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module memory_hard_block_address_gen #(
  parameter int unsigned INDEX_BITS = 20
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // in_tuser: [0] req_type
  // in_tdata: block_index, completed_blocks, thread_index,
  //           state_word_zero, state_word_one (low bit up)
  input  wire logic                              in_tvalid,
  output      logic                              in_tready,
  input  wire logic                              in_tuser,
  input  wire logic [((INDEX_BITS+92+7)/8)*8-1:0] in_tdata,
  // out_tdata: source_block, previous_block, dest_block (low bit up)
  output      logic                              out_tvalid,
  input  wire logic                              out_tready,
  output      logic [mhbag_pkg::OUT_W-1:0]       out_tdata,
  input  wire logic                              cfg_valid,
  output      logic                              cfg_ready,
  input  wire logic [mhbag_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mhbag_pkg::BPT_W-1:0]       cfg_data
);

  localparam int unsigned IB = INDEX_BITS;
  localparam int unsigned KW = $clog2(IB + 1);
  localparam int unsigned CW = (IB > mhbag_pkg::DONE_W) ? IB : mhbag_pkg::DONE_W;
  localparam int unsigned NS = mhbag_pkg::DIV_STAGES + 2;
  localparam int unsigned GW = mhbag_pkg::GIDX_W;
  localparam int unsigned WW = mhbag_pkg::WORD_W;

  typedef struct packed {
    logic                            mode;
    logic [IB-1:0]                   idx;
    logic [mhbag_pkg::DONE_W-1:0]    done;
    logic [WW-1:0]                   s0;
    logic [WW-1:0]                   v;     // v2, then v3, then distance
    logic [IB-1:0]                   back;
    logic [IB-1:0]                   src;
    logic [IB-1:0]                   half;
    logic                            lt;
    logic [WW-1:0]                   dx;    // dividend, shifted out msb first
    logic [mhbag_pkg::TC_W-1:0]      rem;
    logic [GW-1:0]                   own;
    logic [GW-1:0]                   other;
    logic [GW-1:0]                   dest;
    logic [GW-1:0]                   gsrc;
    logic [GW-1:0]                   prev;
  } pipe_t;

  // configuration
  logic [mhbag_pkg::BPT_W-1:0] bpt_r;
  logic [mhbag_pkg::TC_W-1:0]  tc_r;
  logic [mhbag_pkg::TC_W-1:0]  tcv;

  assign cfg_ready = 1'b1;
  assign tcv = (tc_r == '0) ? mhbag_pkg::TC_W'(1) : tc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpt_r <= mhbag_pkg::BPT_RESET;
      tc_r  <= mhbag_pkg::TC_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mhbag_pkg::REG_BPT: bpt_r <= cfg_data;
        mhbag_pkg::REG_TC:  tc_r  <= cfg_data[mhbag_pkg::TC_W-1:0];
        default: ;
      endcase
    end
  end

  // input unpack
  logic [IB-1:0]                 f_idx;
  logic [mhbag_pkg::DONE_W-1:0]  f_done;
  logic [mhbag_pkg::THR_W-1:0]   f_thr;
  logic [WW-1:0]                 f_s0;
  logic [WW-1:0]                 f_s1;

  assign f_idx  = in_tdata[IB-1:0];
  assign f_done = in_tdata[IB+19:IB];
  assign f_thr  = in_tdata[IB+27:IB+20];
  assign f_s0   = in_tdata[IB+59:IB+28];
  assign f_s1   = in_tdata[IB+91:IB+60];

  // pipeline
  pipe_t         pipe_r   [NS];
  pipe_t         pipe_nxt [NS];
  logic [NS-1:0] valid_r;
  logic          en;

  assign en        = !valid_r[NS-1] || out_tready;
  assign in_tready = en;

  // stage 0 helpers: floor(log2 i) and the reversed low bits
  logic [KW-1:0] k0;
  logic [IB-1:0] rev_full;
  logic [KW-1:0] rshift;

  always_comb begin
    k0 = '0;
    for (int j = 0; j < IB; j++) begin
      if (f_idx[j]) k0 = KW'(j);
      rev_full[j] = f_idx[IB-1-j];
    end
    rshift = KW'(IB) - k0;
  end

  logic [63:0]    prod_sq;
  logic [63:0]    prod_cube;
  logic [63:0]    prod_dist;
  logic [IB:0]    slide_sum;
  logic [GW:0]    own_full;
  logic [GW:0]    oth_full;

  assign prod_sq   = 64'(f_s0) * 64'(f_s0);
  assign prod_cube = 64'(pipe_r[0].s0) * 64'(pipe_r[0].v);
  assign prod_dist = 64'(pipe_r[1].back) * 64'(pipe_r[1].v);
  assign slide_sum = {1'b0, pipe_r[0].src} + {1'b0, pipe_r[0].half};
  assign own_full  = (GW+1)'(bpt_r) * (GW+1)'(f_thr);
  assign oth_full  = (GW+1)'(bpt_r) * (GW+1)'(pipe_r[NS-3].rem);

  always_comb begin
    logic [mhbag_pkg::TC_W:0] rem9;
    rem9 = '0;
    for (int s = 0; s < NS; s++) begin
      if (s == 0) begin
        pipe_nxt[s]       = pipe_r[s];
        pipe_nxt[s].mode  = in_tuser;
        pipe_nxt[s].idx   = f_idx;
        pipe_nxt[s].done  = f_done;
        pipe_nxt[s].s0    = f_s0;
        pipe_nxt[s].v     = prod_sq[63:32];
        pipe_nxt[s].back  = f_idx - IB'(1);
        pipe_nxt[s].src   = rev_full >> rshift;
        pipe_nxt[s].half  = IB'(1) << k0;
        pipe_nxt[s].lt    = 1'b0;
        pipe_nxt[s].dx    = in_tuser ? f_s1 : WW'(f_idx);
        pipe_nxt[s].rem   = '0;
        pipe_nxt[s].own   = own_full[GW-1:0];
      end else begin
        pipe_nxt[s] = pipe_r[s-1];
      end
      // remainder by thread count, DIV_STEP bits per stage
      if (s < mhbag_pkg::DIV_STAGES) begin
        for (int b = 0; b < mhbag_pkg::DIV_STEP; b++) begin
          rem9 = {pipe_nxt[s].rem, pipe_nxt[s].dx[WW-1]};
          pipe_nxt[s].dx = pipe_nxt[s].dx << 1;
          if (rem9 >= {1'b0, tcv}) rem9 = rem9 - {1'b0, tcv};
          pipe_nxt[s].rem = rem9[mhbag_pkg::TC_W-1:0];
        end
      end
    end

    // stage 1: cube term, sliding window fix-up
    pipe_nxt[1].v = prod_cube[63:32];
    if (slide_sum < {1'b0, pipe_r[0].idx}) pipe_nxt[1].src = slide_sum[IB-1:0];
    // stage 2: distance back from i-1
    pipe_nxt[2].v = prod_dist[63:32];
    // stage 3: dependent source, and the completed-region test
    if (pipe_r[2].mode) pipe_nxt[3].src = pipe_r[2].back - pipe_r[2].v[IB-1:0];
    pipe_nxt[3].lt = CW'(pipe_nxt[3].src) < CW'(pipe_r[2].done);
    // stage NS-2: base of the other thread's region, destination
    pipe_nxt[NS-2].other = oth_full[GW-1:0];
    pipe_nxt[NS-2].dest  = pipe_r[NS-3].own + GW'(pipe_r[NS-3].idx);
    // stage NS-1: final sums
    pipe_nxt[NS-1].gsrc = GW'(pipe_r[NS-2].src) +
                          (pipe_r[NS-2].lt ? pipe_r[NS-2].other : pipe_r[NS-2].own);
    pipe_nxt[NS-1].prev = pipe_r[NS-2].dest - GW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[NS-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < NS; s++) pipe_r[s] <= pipe_nxt[s];
    end
  end

  assign out_tvalid = valid_r[NS-1];
  assign out_tdata  = mhbag_pkg::OUT_W'({pipe_r[NS-1].dest,
                                         pipe_r[NS-1].prev,
                                         pipe_r[NS-1].gsrc});

endmodule

`default_nettype wire

/* rtl/core/mhbag_checker.sv */
// ----------------------------------------------------------------------------
// mhbag_port_checks
// Port-level checks on the block address generator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mhbag_port_checks (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_tready,
  input wire logic                        out_tvalid,
  input wire logic                        out_tready,
  input wire logic [mhbag_pkg::OUT_W-1:0] out_tdata
);

  localparam int unsigned GW = mhbag_pkg::GIDX_W;

  logic [GW-1:0] prev_f;
  logic [GW-1:0] dest_f;

  assign prev_f = out_tdata[2*GW-1:GW];
  assign dest_f = out_tdata[3*GW-1:2*GW];

  // a held result beat stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  // a held result beat keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("out_tdata changed while stalled");

  // output stall backs up to the input side
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("in_tready high while output stalled");

  // previous block sits right before the destination
  a_prev_dest: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> prev_f == dest_f - GW'(1))
    else $error("previous_block is not dest_block - 1");

endmodule

bind memory_hard_block_address_gen mhbag_port_checks u_mhbag_port_checks (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

/* bench/mhbag_checker.sv */
// ----------------------------------------------------------------------------
// mhbag_checker
// Passive port checker for the block address generator. It tracks the
// geometry registers from the cfg_ beats and computes the source, previous
// and destination indices for every accepted request. Each result beat is
// compared with the oldest prediction.
// ----------------------------------------------------------------------------
module mhbag_checker #(
  parameter int unsigned INDEX_BITS = 20
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  input  logic                                   in_tready,
  input  logic                                   in_tuser,
  input  logic [((INDEX_BITS+92+7)/8)*8-1:0]     in_tdata,
  input  logic                                   out_tvalid,
  input  logic                                   out_tready,
  input  logic [mhbag_pkg::OUT_W-1:0]            out_tdata,
  input  logic                                   cfg_valid,
  input  logic                                   cfg_ready,
  input  logic [mhbag_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mhbag_pkg::BPT_W-1:0]            cfg_data,
  output int                                     fail_count,
  output int                                     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned GW     = mhbag_pkg::GIDX_W;
  localparam int unsigned DONE_B = INDEX_BITS + mhbag_pkg::DONE_W;
  localparam int unsigned THR_B  = DONE_B + mhbag_pkg::THR_W;
  localparam int unsigned SW1_B  = THR_B + mhbag_pkg::WORD_W;

  typedef struct packed {
    logic [GW-1:0] source_block;
    logic [GW-1:0] previous_block;
    logic [GW-1:0] dest_block;
  } block_addr_t;

  logic [mhbag_pkg::BPT_W-1:0] bpt_reg;
  logic [mhbag_pkg::TC_W-1:0]  tc_reg;
  block_addr_t                 addr_q[$];
  block_addr_t                 want;
  block_addr_t                 got;

  function automatic block_addr_t predict_addresses(
    input logic        dependent,
    input logic [63:0] blk,
    input logic [63:0] done,
    input logic [63:0] thr,
    input logic [63:0] sw0,
    input logic [63:0] sw1
  );
    logic [63:0] idx_mask;
    logic [63:0] divisor;
    logic [63:0] own_base;
    logic [63:0] half;
    logic [63:0] src;
    logic [63:0] back;
    logic [63:0] v2;
    logic [63:0] v3;
    logic [63:0] back_dist;
    logic [63:0] dest;
    logic [63:0] prev;
    int unsigned k;
    int unsigned n;
    block_addr_t r;
    idx_mask = (64'd1 << INDEX_BITS) - 64'd1;
    divisor  = (tc_reg == '0) ? 64'd1 : 64'(tc_reg);  // zero threads acts as one
    own_base = 64'(bpt_reg) * thr;
    if (!dependent) begin
      k = 0;
      while (k < 63 && (blk >> (k + 1)) != 64'd0) k++;
      half = 64'd1 << k;
      src = '0;
      for (n = 0; n < k; n++) src = {src[62:0], blk[n]};
      if (src + half < blk) src = src + half;
      if (src < done) src = src + 64'(bpt_reg) * (blk % divisor);
      else src = src + own_base;
    end else begin
      back      = (blk - 64'd1) & idx_mask;  // block zero wraps
      v2        = (sw0 * sw0) >> 32;
      v3        = (sw0 * v2) >> 32;
      back_dist = ({32'd0, back[31:0]} * v3) >> 32;
      src       = back - back_dist;
      if (src < done) src = src + 64'(bpt_reg) * (sw1 % divisor);
      else src = src + own_base;
    end
    dest = own_base + blk;
    prev = dest - 64'd1;
    r.source_block   = src[GW-1:0];
    r.previous_block = prev[GW-1:0];
    r.dest_block     = dest[GW-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      addr_q.delete();
      bpt_reg    = mhbag_pkg::BPT_RESET;
      tc_reg     = mhbag_pkg::TC_RESET;
      fail_count = 0;
      pending    = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == mhbag_pkg::REG_BPT) bpt_reg = cfg_data;
        else if (cfg_index == mhbag_pkg::REG_TC) tc_reg = cfg_data[mhbag_pkg::TC_W-1:0];
      end
      if (in_tvalid && in_tready) begin
        addr_q.push_back(predict_addresses(
          in_tuser,
          64'(in_tdata[INDEX_BITS-1:0]),
          64'(in_tdata[INDEX_BITS +: mhbag_pkg::DONE_W]),
          64'(in_tdata[DONE_B +: mhbag_pkg::THR_W]),
          64'(in_tdata[THR_B +: mhbag_pkg::WORD_W]),
          64'(in_tdata[SW1_B +: mhbag_pkg::WORD_W])));
      end
      if (out_tvalid && out_tready) begin
        if (addr_q.size() == 0) begin
          $error("result beat with no request outstanding");
          fail_count++;
        end else begin
          want = addr_q.pop_front();
          got.source_block   = out_tdata[0 +: GW];
          got.previous_block = out_tdata[GW +: GW];
          got.dest_block     = out_tdata[2*GW +: GW];
          if (got.source_block !== want.source_block) begin
            $error("source_block: expected %0d, actual %0d",
                   want.source_block, got.source_block);
            fail_count++;
          end
          if (got.previous_block !== want.previous_block) begin
            $error("previous_block: expected %0d, actual %0d",
                   want.previous_block, got.previous_block);
            fail_count++;
          end
          if (got.dest_block !== want.dest_block) begin
            $error("dest_block: expected %0d, actual %0d",
                   want.dest_block, got.dest_block);
            fail_count++;
          end
        end
      end
      pending = addr_q.size();
    end
  end

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the block address generator. A directed set hits
// block zero, index and thread extremes, zero threads and 28-bit wrap; then
// random requests run under several register settings with bursty input and
// a stalling sink. Checking is done by mhbag_checker.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned INDEX_BITS = 20;
  localparam int unsigned IN_W = ((INDEX_BITS + 92 + 7) / 8) * 8;
  localparam int unsigned BPT_W  = mhbag_pkg::BPT_W;
  localparam int unsigned TC_W   = mhbag_pkg::TC_W;
  localparam int unsigned DONE_W = mhbag_pkg::DONE_W;
  localparam int unsigned THR_W  = mhbag_pkg::THR_W;
  localparam int unsigned WORD_W = mhbag_pkg::WORD_W;
  localparam logic REQ_INDEPENDENT = 1'b0;
  localparam logic REQ_DEPENDENT   = 1'b1;
  localparam int WATCHDOG_LIMIT  = 1000;
  localparam int DRAIN_CYCLES    = 20;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 150;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic                 in_tuser;   // [0] req_type
  // in_tdata: block_index, completed_blocks, thread_index,
  //           state_word_zero, state_word_one (low bit up)
  logic [IN_W-1:0]      in_tdata;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  // out_tdata: source_block, previous_block, dest_block, pad (low bit up)
  logic [mhbag_pkg::OUT_W-1:0]     out_tdata;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [mhbag_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [BPT_W-1:0]                cfg_data;

  int fail_count;
  int pending;
  int requests_sent  = 0;
  int dependent_sent = 0;
  int settings_count = 0;
  int idle_cycles    = 0;

  // sink stall pattern state
  int   sink_mode      = 0;
  int   sink_mode_left = 0;
  int   sink_hold      = 0;
  logic sink_level     = 1'b1;
  logic sink_next;

  always #5 clk = ~clk;

  memory_hard_block_address_gen #(.INDEX_BITS(INDEX_BITS)) i_dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tuser, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  mhbag_checker #(.INDEX_BITS(INDEX_BITS)) i_checker (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tuser, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .pending
  );

  // sink: always ready, light random, coin flip, or long stall bursts
  always @(negedge clk) begin
    if (sink_mode_left == 0) begin
      sink_mode      = $urandom_range(0, 3);
      sink_mode_left = $urandom_range(20, 200);
    end else begin
      sink_mode_left--;
    end
    case (sink_mode)
      0: sink_next = 1'b1;
      1: sink_next = ($urandom_range(0, 3) != 0);
      2: sink_next = 1'($urandom_range(0, 1));
      default: begin
        if (sink_hold == 0) begin
          sink_level = ~sink_level;
          sink_hold  = sink_level ? $urandom_range(1, 8) : $urandom_range(1, 30);
        end else begin
          sink_hold--;
        end
        sink_next = sink_level;
      end
    endcase
    out_tready <= sink_next;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // called at a falling edge; returns at the falling edge after the beat
  task automatic send_req(input logic kind, input logic [INDEX_BITS-1:0] blk,
                          input logic [DONE_W-1:0] done, input logic [THR_W-1:0] thr,
                          input logic [WORD_W-1:0] sw0, input logic [WORD_W-1:0] sw1);
    logic [IN_W-1:0] beat;
    beat = '0;
    beat[INDEX_BITS-1:0]                          = blk;
    beat[INDEX_BITS +: DONE_W]                    = done;
    beat[INDEX_BITS+DONE_W +: THR_W]              = thr;
    beat[INDEX_BITS+DONE_W+THR_W +: WORD_W]       = sw0;
    beat[INDEX_BITS+DONE_W+THR_W+WORD_W +: WORD_W] = sw1;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= beat;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    requests_sent++;
    if (kind == REQ_DEPENDENT) dependent_sent++;
  endtask

  task automatic write_reg(input logic [mhbag_pkg::CFG_IDX_W-1:0] idx,
                           input logic [BPT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // thread_count rides in the low bits; upper bits of the beat are junk
  task automatic program_geometry(input logic [BPT_W-1:0] bpt, input logic [TC_W-1:0] tc);
    write_reg(mhbag_pkg::REG_BPT, bpt);
    write_reg(mhbag_pkg::REG_TC, {(BPT_W-TC_W)'($urandom), tc});
    cfg_valid <= 1'b0;
    settings_count++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    int              ph;
    int              n;
    int              burst_left;
    int              gap;
    int              k;
    int              tmp;
    logic            kind;
    logic [31:0]     blk;
    logic [31:0]     done;
    logic [31:0]     sw0;
    logic [BPT_W-1:0] bpt;
    logic [TC_W-1:0]  tc;

    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tuser   = 1'b0;
    in_tdata   = '0;
    cfg_valid  = 1'b0;
    cfg_index  = mhbag_pkg::REG_BPT;
    cfg_data   = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset geometry: 1024 blocks, one thread
    send_req(REQ_INDEPENDENT, 9, 0, 3, 32'h0, 32'h0);
    send_req(REQ_DEPENDENT, 600, 20'hFFFFF, 1, 32'hDEADBEEF, 7);
    send_req(REQ_INDEPENDENT, 12, 20'hFFFFF, 0, 32'h0, 32'h0);
    send_req(REQ_DEPENDENT, 2, 0, 255, 32'hFFFF0000, 0);
    drain();

    // widest geometry: outputs wrap past 28 bits
    program_geometry(21'h1FFFFF, 8'd255);
    send_req(REQ_INDEPENDENT, 20'hFFFFF, 20'hFFFFF, 8'hFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_req(REQ_INDEPENDENT, 0, 0, 0, 0, 0);  // dest 0, previous wraps
    send_req(REQ_INDEPENDENT, 1, 0, 1, 0, 0);
    send_req(REQ_INDEPENDENT, 2, 20'hFFFFF, 3, 0, 0);
    send_req(REQ_INDEPENDENT, 3, 0, 200, 0, 0);
    send_req(REQ_INDEPENDENT, 5, 6, 254, 0, 0);
    send_req(REQ_INDEPENDENT, 20'h80000, 0, 7, 0, 0);
    send_req(REQ_INDEPENDENT, 20'h7FFFF, 20'h7FFFF, 254, 0, 0);
    send_req(REQ_DEPENDENT, 0, 0, 0, 32'hFFFFFFFF, 0);  // i-1 wraps
    send_req(REQ_DEPENDENT, 1, 0, 9, 0, 0);
    send_req(REQ_DEPENDENT, 20'hFFFFF, 20'hFFFFF, 255, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_req(REQ_DEPENDENT, 20'h12345, 0, 17, 32'h80000000, 32'h5555AAAA);
    send_req(REQ_DEPENDENT, 1000, 999, 128, 32'hC0000000, 32'd254);
    send_req(REQ_DEPENDENT, 20'hFFFFF, 0, 0, 0, 255);
    drain();

    // zero threads behaves as one
    program_geometry(21'd5, 8'd0);
    send_req(REQ_INDEPENDENT, 6, 100, 4, 0, 0);
    send_req(REQ_DEPENDENT, 50, 20'hFFFFF, 2, 32'h9, 32'hFFFFFFFF);
    send_req(REQ_INDEPENDENT, 255, 0, 255, 0, 0);
    drain();

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin bpt = 21'd1;       tc = 8'd1;   end
        1: begin bpt = 21'h1FFFFF;  tc = 8'd255; end
        2: begin bpt = 21'd1048576; tc = 8'd255; end
        3: begin bpt = 21'd0;       tc = 8'd0;   end
        4: begin bpt = 21'd1024;    tc = 8'd3;   end
        5: begin bpt = 21'd31;      tc = 8'd2;   end
        default: begin
          bpt = BPT_W'($urandom_range(1, 1048576));
          tc  = TC_W'($urandom_range(1, 255));
        end
      endcase
      program_geometry(bpt, tc);
      burst_left = 0;
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          if ($urandom_range(0, 3) != 0) begin
            gap = $urandom_range(1, 12);
            in_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
          end
        end
        burst_left--;
        kind = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
          0: blk = $urandom_range(0, 64);
          1: begin
            k   = $urandom_range(0, INDEX_BITS - 1);
            blk = (32'd1 << k) + $urandom_range(0, 2) - 1;  // around a power of two
          end
          default: blk = $urandom_range(0, 20'hFFFFF);
        endcase
        case ($urandom_range(0, 3))
          0: done = 0;
          1: done = 20'hFFFFF;
          2: begin
            tmp = int'(blk[INDEX_BITS-1:0]) + $urandom_range(0, 32) - 16;
            if (tmp < 0) tmp = 0;
            if (tmp > 20'hFFFFF) tmp = 20'hFFFFF;
            done = tmp;
          end
          default: done = $urandom_range(0, 20'hFFFFF);
        endcase
        case ($urandom_range(0, 3))
          0: sw0 = 32'hFFFFFFFF - $urandom_range(0, 16'hFFFF);
          1: sw0 = $urandom_range(0, 255);
          default: sw0 = $urandom;
        endcase
        send_req(kind, blk[INDEX_BITS-1:0], done[DONE_W-1:0],
                 THR_W'($urandom_range(0, 255)), sw0, $urandom);
      end
      drain();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Ran %0d address requests (%0d cubic distance) over %0d register settings,",
             requests_sent, dependent_sent, settings_count);
    $display("with bursty input and a stalling result sink.");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
